[rtl/rks_pkg.sv]
// rks_pkg: shared constants and types of the record key sorter.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package rks_pkg;

  // Number of records one batch can hold (2 to 64).
  localparam int MAX_RECORDS = 32;
  // Fill count must reach MAX_RECORDS itself.
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef logic signed [31:0] key_t;
  typedef logic [15:0] tag_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic load;   // insert the incoming word at its sorted place
    logic drain;  // shift everything one cell toward the head
  } cell_ctl_t;

endpackage

[rtl/rks_ifs.sv]
// rks_in_if / rks_out_if: valid/ready channels of the record key sorter.
// Depends on rks_pkg for the payload types.
`timescale 1ns / 1ps

interface rks_in_if;
  logic          valid;
  logic          ready;
  rks_pkg::key_t sort_key;
  rks_pkg::tag_t record_tag;
  logic          batch_end;

  modport source (output valid, sort_key, record_tag, batch_end, input ready);
  modport sink (input valid, sort_key, record_tag, batch_end, output ready);
endinterface

interface rks_out_if;
  logic          valid;
  logic          ready;
  rks_pkg::key_t out_key;
  rks_pkg::tag_t out_tag;
  logic          out_last;
  logic          overflowed;

  modport source (output valid, out_key, out_tag, out_last, overflowed, input ready);
  modport sink (input valid, out_key, out_tag, out_last, overflowed, output ready);
endinterface

[rtl/rks_cell.sv]
// rks_cell: one slot of the sorted insertion chain.
// Holds one key/tag pair; depends on rks_pkg.
`timescale 1ns / 1ps

module rks_cell (
  input  logic              clk,
  input  rks_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              prev_ins,
  input  rks_pkg::key_t     new_key,
  input  rks_pkg::tag_t     new_tag,
  input  rks_pkg::key_t     prev_key,
  input  rks_pkg::tag_t     prev_tag,
  input  rks_pkg::key_t     next_key,
  input  rks_pkg::tag_t     next_tag,
  output logic              ins,
  output rks_pkg::key_t     key,
  output rks_pkg::tag_t     tag
);

  rks_pkg::key_t key_r;
  rks_pkg::tag_t tag_r;

  // Empty slot or strictly greater key: new word lands here or further
  // toward the head. Equal keys stay ahead of the newcomer (stable).
  assign ins = !occupied || (key_r > new_key);

  // Load: first inserting slot takes the new word, later ones shift down.
  // Drain: take the neighbor toward the tail.
  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      key_r <= next_key;
      tag_r <= next_tag;
    end else if (ctl.load && ins) begin
      if (prev_ins) begin
        key_r <= prev_key;
        tag_r <= prev_tag;
      end else begin
        key_r <= new_key;
        tag_r <= new_tag;
      end
    end
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

[rtl/record_key_sorter.sv]
// record_key_sorter: top level, a chain of rks_cell slots and its control.
// Depends on rks_pkg, rks_ifs (channel interfaces) and rks_cell.
//
// Usage: words arrive on in_ch (sort_key, record_tag, batch_end). Each
// accepted word is inserted into a chain of MAX_RECORDS cells that stays
// sorted ascending by signed key; equal keys keep arrival order. Loading
// takes one word per cycle; every cell compares the new key with its own
// in parallel and the tail part of the chain shifts down by one cell.
// Once the chain is full, further words are dropped and the batch is
// flagged as overflowed. The word with batch_end set closes the batch:
// in_ch.ready then drops and the cells drain from the head, one word per
// cycle while out_ch is ready, the last one carrying out_last. The first
// result is offered the cycle after batch_end is accepted. If out_ch
// stalls, the head word holds until taken. After the last result the
// block loads the next batch. Reset (rst_n low, synchronous) empties the
// chain and clears the overflow flag; the cell contents themselves are
// not cleared.
`timescale 1ns / 1ps

module record_key_sorter (
  input logic             clk,
  input logic             rst_n,
  rks_in_if.sink          in_ch,
  rks_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  rks_pkg::cnt_t     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  rks_pkg::cell_ctl_t ctl;
  logic              in_acc, out_acc, full;

  logic          ins_a    [rks_pkg::MAX_RECORDS];
  logic          prev_ins [rks_pkg::MAX_RECORDS];
  logic          occ_a    [rks_pkg::MAX_RECORDS];
  rks_pkg::key_t key_a    [rks_pkg::MAX_RECORDS];
  rks_pkg::tag_t tag_a    [rks_pkg::MAX_RECORDS];
  rks_pkg::key_t prev_key [rks_pkg::MAX_RECORDS];
  rks_pkg::tag_t prev_tag [rks_pkg::MAX_RECORDS];
  rks_pkg::key_t next_key [rks_pkg::MAX_RECORDS];
  rks_pkg::tag_t next_tag [rks_pkg::MAX_RECORDS];

  // Handshakes
  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = (state_r == ST_DRAIN);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (count_r == rks_pkg::CNT_W'(rks_pkg::MAX_RECORDS));

  // Head cell is the output word
  assign out_ch.out_key    = key_a[0];
  assign out_ch.out_tag    = tag_a[0];
  assign out_ch.out_last   = (count_r == rks_pkg::CNT_W'(1));
  assign out_ch.overflowed = ovf_r;

  // Cell commands
  always_comb begin
    ctl.load  = in_acc && !full;
    ctl.drain = out_acc;
  end

  // Control: fill count, overflow flag, load/drain state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) ovf_nxt = 1'b1;
          else count_nxt = count_r + rks_pkg::CNT_W'(1);
          if (in_ch.batch_end) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - rks_pkg::CNT_W'(1);
          if (out_ch.out_last) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Cell chain with neighbor wiring
  for (genvar gi = 0; gi < rks_pkg::MAX_RECORDS; gi++) begin : g_cell
    assign occ_a[gi] = (rks_pkg::CNT_W'(gi) < count_r);

    if (gi == 0) begin : g_head
      assign prev_ins[gi] = 1'b0;
      assign prev_key[gi] = in_ch.sort_key;
      assign prev_tag[gi] = in_ch.record_tag;
    end else begin : g_body
      assign prev_ins[gi] = ins_a[gi-1];
      assign prev_key[gi] = key_a[gi-1];
      assign prev_tag[gi] = tag_a[gi-1];
    end

    if (gi == rks_pkg::MAX_RECORDS - 1) begin : g_tail
      assign next_key[gi] = key_a[gi];
      assign next_tag[gi] = tag_a[gi];
    end else begin : g_link
      assign next_key[gi] = key_a[gi+1];
      assign next_tag[gi] = tag_a[gi+1];
    end

    rks_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (occ_a[gi]),
      .prev_ins (prev_ins[gi]),
      .new_key  (in_ch.sort_key),
      .new_tag  (in_ch.record_tag),
      .prev_key (prev_key[gi]),
      .prev_tag (prev_tag[gi]),
      .next_key (next_key[gi]),
      .next_tag (next_tag[gi]),
      .ins      (ins_a[gi]),
      .key      (key_a[gi]),
      .tag      (tag_a[gi])
    );
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rks_pkg::CNT_W'(rks_pkg::MAX_RECORDS))
    else $error("fill count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> count_r != '0)
    else $error("result offered from an empty chain");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_ch.out_last |=> count_r == $past(count_r) - rks_pkg::CNT_W'(1))
    else $error("drain did not remove exactly one word");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_ch.out_last |=> !ovf_r && count_r == '0 && in_ch.ready)
    else $error("batch state not cleared after last result");
`endif

endmodule
